>>> rtl/bmp24_stream_parse_grayscale_core_assert.svh
// Assertion macros for the BMP byte-stream parser core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BMP24_STREAM_PARSE_GRAYSCALE_CORE_ASSERT_SVH
`define BMP24_STREAM_PARSE_GRAYSCALE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, held off during reset
`define BMPG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmp24 core: same-cycle check failed");
// Next-cycle implication, held off during reset
`define BMPG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmp24 core: next-cycle check failed");
`else
`define BMPG_ASSERT_NOW(lbl, ante, cons)
`define BMPG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/bmpgray_pkg.sv
// Shared types and constants for the BMP byte-stream parser and gray converter.
// No dependencies.
`timescale 1ns / 1ps

package bmpgray_pkg;

  // Default image size limits
  localparam int unsigned MAX_WIDTH_DEF  = 4096;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  // Header layout: byte positions of the little-endian fields
  localparam logic [5:0] POS_SIG_B    = 6'd0;
  localparam logic [5:0] POS_SIG_M    = 6'd1;
  localparam logic [5:0] POS_OFF_0    = 6'd10;
  localparam logic [5:0] POS_OFF_1    = 6'd11;
  localparam logic [5:0] POS_OFF_2    = 6'd12;
  localparam logic [5:0] POS_OFF_3    = 6'd13;
  localparam logic [5:0] POS_WID_0    = 6'd18;
  localparam logic [5:0] POS_WID_1    = 6'd19;
  localparam logic [5:0] POS_WID_2    = 6'd20;
  localparam logic [5:0] POS_WID_3    = 6'd21;
  localparam logic [5:0] POS_HGT_0    = 6'd22;
  localparam logic [5:0] POS_HGT_1    = 6'd23;
  localparam logic [5:0] POS_HGT_2    = 6'd24;
  localparam logic [5:0] POS_HGT_3    = 6'd25;
  localparam logic [5:0] POS_BPP_0    = 6'd28;
  localparam logic [5:0] POS_BPP_1    = 6'd29;
  localparam logic [5:0] POS_COMP_0   = 6'd30;
  localparam logic [5:0] POS_COMP_1   = 6'd31;
  localparam logic [5:0] POS_COMP_2   = 6'd32;
  localparam logic [5:0] POS_COMP_3   = 6'd33;
  localparam logic [5:0] POS_HDR_LAST = 6'd53;

  // Total header length (file header plus info header)
  localparam logic [31:0] HDR_BYTES = 32'd54;

  localparam logic [7:0]  CHAR_B    = 8'h42;
  localparam logic [7:0]  CHAR_M    = 8'h4D;
  localparam logic [15:0] DEPTH_24  = 16'd24;

  // Channel index of the red byte, the last of a pixel
  localparam logic [1:0] CH_LAST = 2'd2;

  // Divide by three: multiply by 683 and drop 11 bits (exact for sums up to 765)
  localparam logic [19:0] DIV3_MUL   = 20'd683;
  localparam int unsigned DIV3_SHIFT = 11;

  typedef enum logic [4:0] {
    PH_HEAD = 5'b00001,
    PH_SKIP = 5'b00010,
    PH_PIX  = 5'b00100,
    PH_PAD  = 5'b01000,
    PH_IDLE = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_ACCEPT = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_SIG   = 3'd1,
    ERR_COMP  = 3'd2,
    ERR_DEPTH = 3'd3,
    ERR_OFF   = 3'd4,
    ERR_SIZE  = 3'd5
  } err_t;

  // One result word
  typedef struct packed {
    kind_t       kind;
    err_t        err;
    logic [7:0]  gray;
    logic [11:0] col;
    logic [11:0] row;
    logic        last;
    logic [12:0] wid;
    logic [12:0] hgt;
  } out_item_t;

endpackage

>>> rtl/bmp24_stream_parse_grayscale_core.sv
// Top level of the BMP parser: header check, pixel skip, gray conversion, output skid.
// Depends on bmpgray_pkg and bmp24_stream_parse_grayscale_core_assert.svh.
`timescale 1ns / 1ps
`include "bmp24_stream_parse_grayscale_core_assert.svh"

// Takes a 24-bit BMP file one byte per word and answers with at most one result word per
// byte: a header accept or reject when header byte 53 arrives, then one gray pixel word
// on each red byte. The result is registered on the edge that takes the byte, in the output
// register or, while the sink holds that, in the skid stage, so a byte can be taken every
// cycle while in_stall is low. Behind the output register sits a one-word skid stage;
// in_stall rises only while both hold results, so throughput stays at one byte per cycle
// as long as the sink drains. The gray value is formed in the accepting cycle by one
// 10 x 10 bit multiply with the reciprocal of three.
// A byte with in_start_of_file set restarts parsing at once as byte 0 of a new file.
module bmp24_stream_parse_grayscale_core #(
  parameter int unsigned MAX_WIDTH  = bmpgray_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = bmpgray_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_start_of_file,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [7:0]  out_gray_value,
  output logic [11:0] out_column,
  output logic [11:0] out_row,
  output logic        out_last_of_image,
  output logic [12:0] out_image_width,
  output logic [12:0] out_image_height
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

  // Parser state
  bmpgray_pkg::phase_t phase_r, phase_nxt;
  logic [31:0]        pos_r, pos_nxt;
  logic               sig_r, sig_nxt;
  logic               comp_nz_r, comp_nz_nxt;
  logic [31:0]        off_r, off_nxt;
  logic [31:0]        wid_r, wid_nxt;
  logic [31:0]        hgt_r, hgt_nxt;
  logic [15:0]        bpp_r, bpp_nxt;
  logic [1:0]         ch_idx_r, ch_idx_nxt;
  logic [9:0]         sum_r, sum_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [1:0]         pad_r, pad_nxt;

  // Output register and skid stage
  bmpgray_pkg::out_item_t out_r, out_nxt, skid_r, skid_nxt;
  logic                   out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  bmpgray_pkg::out_item_t res;
  logic                   res_vld;
  logic                   acc, out_fire;
  bmpgray_pkg::phase_t    phase_eff;
  logic [31:0]            pos_eff;
  logic [9:0]             sum_add;
  logic [19:0]            prod;
  logic [31:0]            col_inc, row_inc;
  logic                   row_end, last_px;
  bmpgray_pkg::err_t      hdr_err;

  assign in_stall = skid_vld_r;
  assign acc      = in_valid && !in_stall;
  assign out_fire = out_vld_r && !out_stall;

  // A start mark makes this byte header byte 0
  assign phase_eff = in_start_of_file ? bmpgray_pkg::PH_HEAD : phase_r;
  assign pos_eff   = in_start_of_file ? 32'd0 : pos_r;

  // Pixel arithmetic
  assign sum_add = sum_r + {2'b00, in_byte};
  assign prod    = 20'(sum_add) * bmpgray_pkg::DIV3_MUL;
  assign col_inc = 32'(col_r) + 32'd1;
  assign row_inc = 32'(row_r) + 32'd1;
  assign row_end = (col_inc == wid_r);
  assign last_px = row_end && (row_inc == hgt_r);

  // Header verdict, first failure wins
  always_comb begin
    if (!sig_r) begin
      hdr_err = bmpgray_pkg::ERR_SIG;
    end else if (comp_nz_r) begin
      hdr_err = bmpgray_pkg::ERR_COMP;
    end else if (bpp_r != bmpgray_pkg::DEPTH_24) begin
      hdr_err = bmpgray_pkg::ERR_DEPTH;
    end else if (off_r < bmpgray_pkg::HDR_BYTES) begin
      hdr_err = bmpgray_pkg::ERR_OFF;
    end else if (wid_r > 32'(MAX_WIDTH) || hgt_r > 32'(MAX_HEIGHT)) begin
      hdr_err = bmpgray_pkg::ERR_SIZE;
    end else begin
      hdr_err = bmpgray_pkg::ERR_NONE;
    end
  end

  // Advance the parser on each accepted word
  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    sig_nxt     = sig_r;
    comp_nz_nxt = comp_nz_r;
    off_nxt     = off_r;
    wid_nxt     = wid_r;
    hgt_nxt     = hgt_r;
    bpp_nxt     = bpp_r;
    ch_idx_nxt  = ch_idx_r;
    sum_nxt     = sum_r;
    col_nxt     = col_r;
    row_nxt     = row_r;
    pad_nxt     = pad_r;
    res         = '0;
    res_vld     = 1'b0;
    if (acc) begin
      if (in_start_of_file) begin
        phase_nxt  = bmpgray_pkg::PH_HEAD;
        ch_idx_nxt = '0;
        sum_nxt    = '0;
        col_nxt    = '0;
        row_nxt    = '0;
        pad_nxt    = '0;
      end
      case (phase_eff)
        bmpgray_pkg::PH_HEAD: begin
          pos_nxt = pos_eff + 32'd1;
          case (pos_eff[5:0])
            bmpgray_pkg::POS_SIG_B:  sig_nxt = (in_byte == bmpgray_pkg::CHAR_B);
            bmpgray_pkg::POS_SIG_M:  sig_nxt = sig_r && (in_byte == bmpgray_pkg::CHAR_M);
            bmpgray_pkg::POS_OFF_0:  off_nxt[7:0]   = in_byte;
            bmpgray_pkg::POS_OFF_1:  off_nxt[15:8]  = in_byte;
            bmpgray_pkg::POS_OFF_2:  off_nxt[23:16] = in_byte;
            bmpgray_pkg::POS_OFF_3:  off_nxt[31:24] = in_byte;
            bmpgray_pkg::POS_WID_0:  wid_nxt[7:0]   = in_byte;
            bmpgray_pkg::POS_WID_1:  wid_nxt[15:8]  = in_byte;
            bmpgray_pkg::POS_WID_2:  wid_nxt[23:16] = in_byte;
            bmpgray_pkg::POS_WID_3:  wid_nxt[31:24] = in_byte;
            bmpgray_pkg::POS_HGT_0:  hgt_nxt[7:0]   = in_byte;
            bmpgray_pkg::POS_HGT_1:  hgt_nxt[15:8]  = in_byte;
            bmpgray_pkg::POS_HGT_2:  hgt_nxt[23:16] = in_byte;
            bmpgray_pkg::POS_HGT_3:  hgt_nxt[31:24] = in_byte;
            bmpgray_pkg::POS_BPP_0:  bpp_nxt[7:0]   = in_byte;
            bmpgray_pkg::POS_BPP_1:  bpp_nxt[15:8]  = in_byte;
            bmpgray_pkg::POS_COMP_0: comp_nz_nxt = (in_byte != 8'd0);
            bmpgray_pkg::POS_COMP_1,
            bmpgray_pkg::POS_COMP_2,
            bmpgray_pkg::POS_COMP_3: comp_nz_nxt = comp_nz_r || (in_byte != 8'd0);
            bmpgray_pkg::POS_HDR_LAST: begin
              res_vld = 1'b1;
              res.err = hdr_err;
              res.wid = wid_r[12:0];
              res.hgt = hgt_r[12:0];
              if (hdr_err != bmpgray_pkg::ERR_NONE) begin
                res.kind  = bmpgray_pkg::KIND_REJECT;
                phase_nxt = bmpgray_pkg::PH_IDLE;
              end else begin
                res.kind = bmpgray_pkg::KIND_ACCEPT;
                if (wid_r == 32'd0 || hgt_r == 32'd0) begin
                  phase_nxt = bmpgray_pkg::PH_IDLE;
                end else if (off_r == bmpgray_pkg::HDR_BYTES) begin
                  phase_nxt = bmpgray_pkg::PH_PIX;
                end else begin
                  phase_nxt = bmpgray_pkg::PH_SKIP;
                end
              end
            end
            default: ;
          endcase
        end
        bmpgray_pkg::PH_SKIP: begin
          // Drop bytes between header and pixel data
          pos_nxt = pos_r + 32'd1;
          if (pos_nxt == off_r) begin
            phase_nxt = bmpgray_pkg::PH_PIX;
          end
        end
        bmpgray_pkg::PH_PIX: begin
          if (ch_idx_r < bmpgray_pkg::CH_LAST) begin
            ch_idx_nxt = ch_idx_r + 2'd1;
            sum_nxt    = sum_add;
          end else begin
            ch_idx_nxt = '0;
            sum_nxt    = '0;
            res_vld    = 1'b1;
            res.kind   = bmpgray_pkg::KIND_PIXEL;
            res.err    = bmpgray_pkg::ERR_NONE;
            res.gray   = prod[bmpgray_pkg::DIV3_SHIFT +: 8];
            res.col    = 12'((32'(col_r)) & 32'hFFF);
            res.row    = 12'((32'(row_r)) & 32'hFFF);
            res.last   = last_px;
            if (last_px) begin
              phase_nxt = bmpgray_pkg::PH_IDLE;
            end else if (row_end) begin
              col_nxt = '0;
              row_nxt = ROW_W'(row_inc);
              pad_nxt = wid_r[1:0];
              if (wid_r[1:0] != 2'd0) begin
                phase_nxt = bmpgray_pkg::PH_PAD;
              end
            end else begin
              col_nxt = COL_W'(col_inc);
            end
          end
        end
        bmpgray_pkg::PH_PAD: begin
          // Drop row padding
          if (pad_r != 2'd0) begin
            pad_nxt = pad_r - 2'd1;
          end
          if (pad_r <= 2'd1) begin
            phase_nxt = bmpgray_pkg::PH_PIX;
          end
        end
        default: ;
      endcase
    end
  end

  // Steer results into the output register or, when it is held, the skid stage
  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (skid_vld_r) begin
      if (out_fire) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (out_vld_r && !out_fire) begin
      if (res_vld) begin
        skid_nxt     = res;
        skid_vld_nxt = 1'b1;
      end
    end else begin
      out_nxt     = res;
      out_vld_nxt = res_vld;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= bmpgray_pkg::PH_HEAD;
      pos_r      <= '0;
      sig_r      <= 1'b0;
      comp_nz_r  <= 1'b0;
      ch_idx_r   <= '0;
      sum_r      <= '0;
      col_r      <= '0;
      row_r      <= '0;
      pad_r      <= '0;
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      pos_r      <= pos_nxt;
      sig_r      <= sig_nxt;
      comp_nz_r  <= comp_nz_nxt;
      ch_idx_r   <= ch_idx_nxt;
      sum_r      <= sum_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      pad_r      <= pad_nxt;
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Header fields and result words; always rewritten before use
  always_ff @(posedge clk) begin
    off_r  <= off_nxt;
    wid_r  <= wid_nxt;
    hgt_r  <= hgt_nxt;
    bpp_r  <= bpp_nxt;
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid         = out_vld_r;
  assign out_kind          = out_r.kind;
  assign out_error_code    = out_r.err;
  assign out_gray_value    = out_r.gray;
  assign out_column        = out_r.col;
  assign out_row           = out_r.row;
  assign out_last_of_image = out_r.last;
  assign out_image_width   = out_r.wid;
  assign out_image_height  = out_r.hgt;

  // Checks
  `BMPG_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r)
  `BMPG_ASSERT_NEXT(a_result_lands, res_vld, out_vld_r)
  `BMPG_ASSERT_NOW(a_chan_index_range, 1'b1, ch_idx_r <= bmpgray_pkg::CH_LAST)
  `BMPG_ASSERT_NOW(a_pad_nonzero, phase_r == bmpgray_pkg::PH_PAD, pad_r != 2'd0)

endmodule
